// File: src/crbp_pkg.sv
// Shared types, codes and helpers for the CSMA retry backoff policy core.
// No dependencies; used by every module of the block.
package crbp_pkg;

   localparam int PACKET_SLOTS = 16;
   localparam int SLOT_W       = 4;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int WINDOW_W     = 24;        // (2^8-1) * 65535 fits in 24 bits
   localparam int DIV_STEPS    = 16;        // one remainder bit per step
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [15:0] LFSR_MASK  = 16'hB400;
   localparam logic [15:0] SEED_RESET = 16'd44257;
   localparam logic [3:0]  BE_MAX     = 4'd8;

   // request function codes
   localparam logic FUNC_SEND   = 1'b0;
   localparam logic FUNC_REPORT = 1'b1;

   // report status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_COLLISION = 3'd1;
   localparam logic [2:0] ST_NOACK     = 3'd2;
   localparam logic [2:0] ST_DEFERRED  = 3'd3;

   // result action codes
   localparam logic ACT_SCHED = 1'b0;
   localparam logic ACT_DONE  = 1'b1;

   // final status codes
   localparam logic [1:0] FS_OK        = 2'd0;
   localparam logic [1:0] FS_COLLISION = 2'd1;
   localparam logic [1:0] FS_NOACK     = 2'd2;
   localparam logic [1:0] FS_ERROR     = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_EXPONENT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COLL_RST  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_BO    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_RETRY = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SEED      = 3'd5;

   typedef struct packed {
      logic              func;
      logic [SLOT_W-1:0] slot;
      logic [2:0]        status;
      logic [7:0]        attempt_count;
   } req_type;

   typedef struct packed {
      logic              action;
      logic [SLOT_W-1:0] out_slot;
      logic [15:0]       delay_ticks;
      logic [1:0]        final_status;
      logic [15:0]       sequence_number;
      logic [7:0]        total_transmissions;
   } rsp_type;

   typedef struct packed {
      logic [15:0] backoff_period_ticks;
      logic [3:0]  window_exp;
      logic [3:0]  collision_reset_value;
      logic [2:0]  max_backoffs;
      logic [2:0]  max_frame_retries;
   } cfg_type;

   // one classified beat handed from front to back
   typedef struct packed {
      rsp_type     rsp;       // delay_ticks filled in by the back end
      logic        draw;      // back end must reduce rand_val by the window
      logic [15:0] rand_val;
   } job_type;

   function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8] ? 8'hFF : s[7:0];
   endfunction

   function automatic logic [15:0] lfsr_next(input logic [15:0] v);
      return v[0] ? ((v >> 1) ^ LFSR_MASK) : (v >> 1);
   endfunction

endpackage

// File: src/crbp_queue.sv
// Two-entry job queue between the classifying front end and the backoff back end.
// Depends on crbp_pkg (job_type, QUEUE_DEPTH).
module crbp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  crbp_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output crbp_pkg::job_type pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(crbp_pkg::QUEUE_DEPTH);

   crbp_pkg::job_type mem_ff [crbp_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]    count_ff, count_in;

   assign full     = (count_ff == (PTR_W+1)'(crbp_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push && !full) begin
         wr_ptr_in = (32'(wr_ptr_ff) == crbp_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop && !empty) begin
         rd_ptr_in = (32'(rd_ptr_ff) == crbp_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
         count_in = count_ff + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/crbp_front.sv
// Front end: accepts request beats, updates per-slot counters, sequence and LFSR,
// and queues one job per result. Depends on crbp_pkg.
module crbp_front (
   input  logic              clock,
   input  logic              reset,
   input  crbp_pkg::cfg_type cfg,
   input  logic              seed_load,
   input  logic [15:0]       seed_value,
   input  logic              req_valid,
   output logic              req_stall,
   input  crbp_pkg::req_type req_data,
   output logic              push,
   output crbp_pkg::job_type push_data,
   input  logic              queue_full
);

   logic [7:0]  coll_ff  [crbp_pkg::PACKET_SLOTS];
   logic [7:0]  trans_ff [crbp_pkg::PACKET_SLOTS];
   logic [15:0] seq_ff, seq_in;
   logic [15:0] lfsr_ff, lfsr_in;

   logic        accept;
   logic        in_range;
   logic        emit;
   logic        wr_slot;
   logic [7:0]  cc, tc, cc_n, tc_n, c_sum;
   logic [7:0]  limit;
   logic [15:0] seq_use;
   logic [15:0] seed_eff;
   logic        be_zero;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign in_range  = (32'(req_data.slot) < crbp_pkg::PACKET_SLOTS);
   assign cc        = coll_ff[req_data.slot];
   assign tc        = trans_ff[req_data.slot];
   assign limit     = 8'({1'b0, cfg.max_frame_retries}) + 8'd1;
   assign seq_use   = (seq_ff == '0) ? 16'd1 : seq_ff;
   assign seed_eff  = (seed_value == '0) ? 16'd1 : seed_value;
   assign be_zero   = (cfg.window_exp == '0);
   assign c_sum     = crbp_pkg::sat_add8(cc, req_data.attempt_count);

   always_comb begin
      emit      = 1'b0;
      wr_slot   = 1'b0;
      cc_n      = cc;
      tc_n      = tc;
      push_data = '0;
      push_data.rsp.out_slot = req_data.slot;
      if (in_range) begin
         if (req_data.func == crbp_pkg::FUNC_SEND) begin
            emit    = 1'b1;
            wr_slot = 1'b1;
            cc_n    = '0;
            tc_n    = '0;
            push_data.rsp.action          = crbp_pkg::ACT_SCHED;
            push_data.rsp.sequence_number = seq_use;
            push_data.draw                = !be_zero;
         end else begin
            unique case (req_data.status)
               crbp_pkg::ST_OK: begin
                  emit    = 1'b1;
                  wr_slot = 1'b1;
                  cc_n    = 8'(cfg.collision_reset_value);
                  tc_n    = crbp_pkg::sat_add8(tc, req_data.attempt_count);
                  push_data.rsp.action       = crbp_pkg::ACT_DONE;
                  push_data.rsp.final_status = crbp_pkg::FS_OK;
               end
               crbp_pkg::ST_COLLISION, crbp_pkg::ST_NOACK: begin
                  emit    = 1'b1;
                  wr_slot = 1'b1;
                  if (req_data.status == crbp_pkg::ST_COLLISION) begin
                     if (c_sum > 8'(cfg.max_backoffs)) begin
                        cc_n = 8'(cfg.collision_reset_value);
                        tc_n = crbp_pkg::sat_add8(tc, 8'd1);
                     end else begin
                        cc_n = c_sum;
                     end
                  end else begin
                     cc_n = 8'(cfg.collision_reset_value);
                     tc_n = crbp_pkg::sat_add8(tc, req_data.attempt_count);
                  end
                  if (tc_n >= limit) begin
                     push_data.rsp.action       = crbp_pkg::ACT_DONE;
                     push_data.rsp.final_status =
                        (req_data.status == crbp_pkg::ST_COLLISION) ?
                        crbp_pkg::FS_COLLISION : crbp_pkg::FS_NOACK;
                  end else begin
                     push_data.rsp.action = crbp_pkg::ACT_SCHED;
                     push_data.draw       = !be_zero;
                  end
               end
               crbp_pkg::ST_DEFERRED: begin
                  emit = 1'b0;
               end
               default: begin
                  // unknown status: finish with error, counters untouched
                  emit = 1'b1;
                  push_data.rsp.action       = crbp_pkg::ACT_DONE;
                  push_data.rsp.final_status = crbp_pkg::FS_ERROR;
               end
            endcase
         end
      end
      push_data.rsp.total_transmissions = tc_n;
      push_data.rand_val                = crbp_pkg::lfsr_next(lfsr_ff);
   end

   assign push = accept && emit;

   always_comb begin
      seq_in  = seq_ff;
      lfsr_in = lfsr_ff;
      priority if (seed_load) begin
         seq_in  = seed_eff;
         lfsr_in = seed_eff;
      end else if (push) begin
         if (req_data.func == crbp_pkg::FUNC_SEND) begin
            seq_in = seq_use + 16'd1;
         end
         if (push_data.draw) begin
            lfsr_in = push_data.rand_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff  <= crbp_pkg::SEED_RESET;
         lfsr_ff <= crbp_pkg::SEED_RESET;
         for (int i = 0; i < crbp_pkg::PACKET_SLOTS; i++) begin
            coll_ff[i]  <= '0;
            trans_ff[i] <= '0;
         end
      end else begin
         seq_ff  <= seq_in;
         lfsr_ff <= lfsr_in;
         if (accept && wr_slot) begin
            coll_ff[req_data.slot]  <= cc_n;
            trans_ff[req_data.slot] <= tc_n;
         end
      end
   end

endmodule

// File: src/crbp_back.sv
// Back end: reduces the drawn random value modulo the backoff window, one bit per
// cycle, and holds the result beat. Depends on crbp_pkg.
module crbp_back (
   input  logic              clock,
   input  logic              reset,
   input  crbp_pkg::cfg_type cfg,
   output logic              pop,
   input  crbp_pkg::job_type pop_data,
   input  logic              queue_empty,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output crbp_pkg::rsp_type rsp_data
);

   typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} state_type;

   state_type                        state_ff;
   crbp_pkg::job_type                job_ff;
   logic [crbp_pkg::WINDOW_W:0]      rem_ff;
   logic [15:0]                      dividend_ff;
   logic [crbp_pkg::DIV_CNT_W-1:0]   cnt_ff;
   logic [crbp_pkg::WINDOW_W-1:0]    window_ff;
   logic                             rsp_valid_ff;
   crbp_pkg::rsp_type                rsp_data_ff;

   logic [3:0]                       be_eff;
   logic [7:0]                       be_mask;
   logic [15:0]                      period_eff;
   logic [crbp_pkg::WINDOW_W:0]      trial;
   logic [crbp_pkg::WINDOW_W:0]      rem_in;
   logic                             load_out;
   crbp_pkg::rsp_type                out_beat;

   assign be_eff     = (cfg.window_exp > crbp_pkg::BE_MAX) ?
                       crbp_pkg::BE_MAX : cfg.window_exp;
   assign be_mask    = 8'((9'd1 << be_eff) - 9'd1);
   assign period_eff = (cfg.backoff_period_ticks == '0) ? 16'd1 : cfg.backoff_period_ticks;

   // restoring remainder step
   assign trial  = {rem_ff[crbp_pkg::WINDOW_W-1:0], dividend_ff[15]};
   assign rem_in = (trial >= {1'b0, window_ff}) ? (trial - {1'b0, window_ff}) : trial;

   assign pop       = (state_ff == S_IDLE) && !queue_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // output register is free when empty or when its beat leaves this edge
   assign load_out = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      out_beat             = job_ff.rsp;
      out_beat.delay_ticks = job_ff.draw ? rem_ff[15:0] : 16'd0;
   end

   // window only follows configuration, so one register stage is free
   always_ff @(posedge clock) begin
      window_ff <= crbp_pkg::WINDOW_W'(be_mask) * crbp_pkg::WINDOW_W'(period_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (!queue_empty) begin
                  job_ff      <= pop_data;
                  rem_ff      <= '0;
                  dividend_ff <= pop_data.rand_val;
                  cnt_ff      <= crbp_pkg::DIV_CNT_W'(crbp_pkg::DIV_STEPS - 1);
                  state_ff    <= pop_data.draw ? S_DIV : S_OUT;
               end
            end
            S_DIV: begin
               rem_ff      <= rem_in;
               dividend_ff <= {dividend_ff[14:0], 1'b0};
               cnt_ff      <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (load_out) begin
                  rsp_data_ff <= out_beat;
                  state_ff    <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// File: src/csma_retry_backoff_policy_core.sv
// Top level of the CSMA retry backoff policy core: register file, front end,
// job queue and backoff back end. Depends on crbp_pkg, crbp_front, crbp_queue, crbp_back.
//
//   channel | direction | handshake                 | beat
//   req     | in        | req_valid / req_stall     | crbp_pkg::req_type
//   rsp     | out       | rsp_valid / rsp_stall     | crbp_pkg::rsp_type
//   csr     | in        | csr_we (no wait)          | csr_index, csr_wdata
//
// A request beat is classified in its accept cycle; counters, sequence and LFSR
// update there. A beat that schedules a backoff passes the back end in order: pop,
// 16 remainder steps, output load; one without a draw skips the remainder steps.
// The back end pops no new job until its current beat has moved to the output register.
// Reset is synchronous and restores counters, pointers, state and configuration.
// rsp_stall holds the output register; req_stall rises only when the job queue fills.
module csma_retry_backoff_policy_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  crbp_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output crbp_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [crbp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [crbp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   crbp_pkg::cfg_type cfg_ff;
   logic              seed_load;
   logic              push, pop, queue_full, queue_empty;
   crbp_pkg::job_type push_data, pop_data;

   // seed write also reloads LFSR and sequence counter in the front end
   assign seed_load = csr_we && (csr_index == crbp_pkg::REG_SEED);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.backoff_period_ticks  <= 16'd0;
         cfg_ff.window_exp            <= 4'd4;
         cfg_ff.collision_reset_value <= 4'd0;
         cfg_ff.max_backoffs          <= 3'd5;
         cfg_ff.max_frame_retries     <= 3'd7;
      end else if (csr_we) begin
         unique case (csr_index)
            crbp_pkg::REG_PERIOD:    cfg_ff.backoff_period_ticks  <= csr_wdata;
            crbp_pkg::REG_EXPONENT:  cfg_ff.window_exp            <= csr_wdata[3:0];
            crbp_pkg::REG_COLL_RST:  cfg_ff.collision_reset_value <= csr_wdata[3:0];
            crbp_pkg::REG_MAX_BO:    cfg_ff.max_backoffs          <= csr_wdata[2:0];
            crbp_pkg::REG_MAX_RETRY: cfg_ff.max_frame_retries     <= csr_wdata[2:0];
            default: ;  // seed handled by seed_load; other indexes ignored
         endcase
      end
   end

   crbp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .seed_load  (seed_load),
      .seed_value (csr_wdata),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   crbp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   crbp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .pop         (pop),
      .pop_data    (pop_data),
      .queue_empty (queue_empty),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// File: src/crbp_checker.sv
// Port-level checker for the CSMA retry backoff policy core, with its bind.
// Depends on crbp_pkg and csma_retry_backoff_policy_core.
module crbp_port_assert (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input crbp_pkg::rsp_type rsp_data
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a finished packet carries no delay and no sequence number
   a_done_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.action == crbp_pkg::ACT_DONE |->
         rsp_data.delay_ticks == '0 && rsp_data.sequence_number == '0)
      else $error("finished beat with delay or sequence");

   // a sequence number only comes with a fresh send
   a_seq_send: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.sequence_number != '0 |->
         rsp_data.action == crbp_pkg::ACT_SCHED && rsp_data.total_transmissions == '0 &&
         rsp_data.final_status == crbp_pkg::FS_OK)
      else $error("sequence number on a non-send beat");

endmodule

bind csma_retry_backoff_policy_core crbp_port_assert u_crbp_port_assert (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
